// File: src/geb_pkg.sv
// geb_pkg: shared types and constants for the gated event buffer
// used by geb_ctrl, geb_datapath and gated_event_buffer_with_link_timeout
package geb_pkg;

  localparam int RING_DEPTH = 16;
  localparam int EVENT_BITS = 32;
  localparam int TDATA_W    = ((EVENT_BITS + 7) / 8) * 8;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int IDLE_W     = 16;
  localparam int TMO_W      = 16;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = TMO_W'(300);
  localparam logic [IDLE_W-1:0] IDLE_MAX      = '1;

  typedef logic [EVENT_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVENT = 2'd1,
    OP_IDENT = 2'd2,
    OP_CMD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_MARKER = 2'd0,
    KIND_LIVE   = 2'd1,
    KIND_REPLAY = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic do_tick;
    logic do_event;
    logic do_ident;
    logic do_cmd;
    logic do_replay;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic link_up;
    logic ring_empty;
    logic last_entry;
  } status_t;

endpackage

// File: src/geb_ctrl.sv
// geb_ctrl: controller state machine for the gated event buffer
// depends on geb_pkg; drives handshakes and commands for geb_datapath
module geb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        op,
  output logic              m_tvalid,
  input  logic              m_tready,
  output geb_pkg::cmd_t     cmd,
  input  geb_pkg::status_t  status
);

  typedef enum logic {
    ST_IDLE,
    ST_REPLAY
  } state_t;

  state_t state;
  logic   slot_free;
  logic   accept;
  logic   load_out;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (geb_pkg::op_t'(op))
        geb_pkg::OP_TICK:  cmd.do_tick  = 1'b1;
        geb_pkg::OP_EVENT: cmd.do_event = 1'b1;
        geb_pkg::OP_IDENT: cmd.do_ident = 1'b1;
        geb_pkg::OP_CMD:   cmd.do_cmd   = 1'b1;
        default:           cmd = '0;
      endcase
    end
    cmd.do_replay = (state == ST_REPLAY) && slot_free;
  end

  assign load_out = (cmd.do_event && status.link_up) || cmd.do_ident || cmd.do_replay;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.do_ident && !status.ring_empty) begin
            state <= ST_REPLAY;
          end
        end
        ST_REPLAY: begin
          if (cmd.do_replay && status.last_entry) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/geb_datapath.sv
// geb_datapath: ring store, indexes, link and idle state, output word register
// depends on geb_pkg; commanded by geb_ctrl
module geb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  geb_pkg::cmd_t               cmd,
  output geb_pkg::status_t            status,
  input  geb_pkg::word_t              event_word,
  input  logic                        cfg_write,
  input  logic [geb_pkg::TMO_W-1:0]   cfg_data,
  output logic [1:0]                  kind,
  output geb_pkg::word_t              event_word_out,
  output logic                        last
);

  geb_pkg::word_t                ring [geb_pkg::RING_DEPTH];
  geb_pkg::idx_t                 write_index;
  geb_pkg::idx_t                 read_index;
  geb_pkg::cnt_t                 fill_count;
  logic                          link_up;
  logic [geb_pkg::IDLE_W-1:0]    idle_count;
  logic [geb_pkg::TMO_W-1:0]     timeout_ticks;
  logic [geb_pkg::IDLE_W-1:0]    idle_next;
  geb_pkg::idx_t                 write_index_next;
  geb_pkg::idx_t                 read_index_next;
  logic                          ring_full;

  localparam geb_pkg::idx_t IDX_LAST = geb_pkg::IDX_W'(geb_pkg::RING_DEPTH - 1);
  localparam geb_pkg::cnt_t CNT_FULL = geb_pkg::CNT_W'(geb_pkg::RING_DEPTH);
  localparam geb_pkg::cnt_t CNT_ONE  = geb_pkg::CNT_W'(1);

  assign ring_full         = (fill_count == CNT_FULL);
  assign write_index_next  = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
  assign read_index_next   = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
  assign idle_next         = (idle_count == geb_pkg::IDLE_MAX) ? idle_count
                                                               : idle_count + 1'b1;

  assign status.link_up    = link_up;
  assign status.ring_empty = (fill_count == '0);
  assign status.last_entry = (fill_count == CNT_ONE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index   <= '0;
      read_index    <= '0;
      fill_count    <= '0;
      link_up       <= 1'b0;
      idle_count    <= '0;
      timeout_ticks <= geb_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.do_tick) begin
        idle_count <= idle_next;
        if (link_up && (idle_next > timeout_ticks)) begin
          link_up <= 1'b0;
        end
      end
      if (cmd.do_cmd) begin
        idle_count <= '0;
      end
      if (cmd.do_ident) begin
        idle_count <= '0;
        link_up    <= 1'b1;
      end
      if (cmd.do_event && !link_up) begin
        write_index <= write_index_next;
        if (ring_full) begin
          read_index <= read_index_next;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.do_replay) begin
        read_index <= read_index_next;
        fill_count <= fill_count - 1'b1;
      end
    end
  end

  // payload: ring entries and output word
  always_ff @(posedge clk) begin
    if (cmd.do_event && !link_up) begin
      ring[write_index] <= event_word;
    end
    if (cmd.do_event && link_up) begin
      kind           <= geb_pkg::KIND_LIVE;
      event_word_out <= event_word;
      last           <= 1'b1;
    end else if (cmd.do_ident) begin
      kind           <= geb_pkg::KIND_MARKER;
      event_word_out <= '0;
      last           <= status.ring_empty;
    end else if (cmd.do_replay) begin
      kind           <= geb_pkg::KIND_REPLAY;
      event_word_out <= ring[read_index];
      last           <= status.last_entry;
    end
  end

endmodule

// File: src/gated_event_buffer_with_link_timeout.sv
// gated_event_buffer_with_link_timeout: top level of the gated event buffer
// depends on geb_pkg, geb_ctrl and geb_datapath
//
// usage
//   slave stream: one input word per handshake; tuser carries the opcode
//   (tick, event, identify request, command seen), tdata the event word
//   master stream: result words; tuser carries the kind (identify marker,
//   live event, replayed event), tdata the event word, tlast marks the final
//   result caused by one input word
//   cfg channel: writes the 16-bit timeout in ticks, taken every cycle
//   output: a result is registered and shows on the master side in the cycle after acceptance
//   throughput: one tick, command or event word per cycle unless stalled;
//   an identify request sends its marker, then one buffered event per
//   unstalled cycle from the ring register file; s_tready is low meanwhile
//   one output register parts the two sides: a new word is taken in the cycle
//   the pending result is taken, or while none is pending
//   reset: link down, ring empty, idle count zero, timeout 300 ticks
//   receiver stall: the result holds in the output register and s_tready
//   drops until it is taken; the ring is not touched while stalled
module gated_event_buffer_with_link_timeout (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [geb_pkg::TDATA_W-1:0]   s_tdata,   // [31:0] event_word
  input  logic [1:0]                    s_tuser,   // [1:0] opcode
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [geb_pkg::TDATA_W-1:0]   m_tdata,   // [31:0] event_word_out
  output logic [1:0]                    m_tuser,   // [1:0] kind
  output logic                          m_tlast,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [geb_pkg::TMO_W-1:0]     cfg_data   // timeout_ticks
);

  geb_pkg::cmd_t    cmd;
  geb_pkg::status_t status;
  geb_pkg::word_t   word_out;

  // config is always accepted
  assign cfg_ready = 1'b1;

  geb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  geb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .event_word     (s_tdata[geb_pkg::EVENT_BITS-1:0]),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .kind           (m_tuser),
    .event_word_out (word_out),
    .last           (m_tlast)
  );

  // zero-fill up to whole bytes
  assign m_tdata = geb_pkg::TDATA_W'(word_out);

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for gated_event_buffer_with_link_timeout
// a scoreboard class predicts every result word; plain tasks drive the streams
// depends on geb_pkg and the block's rtl
module testbench;
  import geb_pkg::*;

  localparam int unsigned RUN_LIMIT    = 3_000_000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned RANDOM_WORDS = 200;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    kind_t kind;
    word_t word;
    logic  last;
  } result_t;

  // shadow of the buffer state plus the queue of result words still owed
  class replay_scoreboard;
    word_t             ring [RING_DEPTH];
    idx_t              wr_ptr;
    idx_t              rd_ptr;
    cnt_t              fill;
    logic              link_is_up;
    logic [IDLE_W-1:0] idle_ticks;
    logic [TMO_W-1:0]  timeout;
    result_t           owed_words [$];
    int unsigned       mismatches;

    function new();
      wr_ptr     = '0;
      rd_ptr     = '0;
      fill       = '0;
      link_is_up = 1'b0;
      idle_ticks = '0;
      timeout    = TIMEOUT_RESET;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    function idx_t step_ptr(idx_t p);
      return (p == idx_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function void owe(kind_t kind, word_t word, logic last);
      result_t r;
      r.kind = kind;
      r.word = word;
      r.last = last;
      owed_words.push_back(r);
    endfunction

    function void note_timeout(logic [TMO_W-1:0] v);
      timeout = v;
    endfunction

    // one accepted input word
    function void accept_word(op_t op, word_t w);
      case (op)
        OP_TICK: begin
          if (idle_ticks != IDLE_MAX) idle_ticks++;
          if (link_is_up && idle_ticks > timeout) link_is_up = 1'b0;
        end
        OP_EVENT: begin
          if (link_is_up) begin
            owe(KIND_LIVE, w, 1'b1);
          end else begin
            // full ring drops its oldest entry
            ring[wr_ptr] = w;
            wr_ptr = step_ptr(wr_ptr);
            if (fill < RING_DEPTH) fill++;
            else rd_ptr = step_ptr(rd_ptr);
          end
        end
        OP_IDENT: begin
          link_is_up = 1'b1;
          idle_ticks = '0;
          owe(KIND_MARKER, '0, fill == 0);
          while (fill != 0) begin
            owe(KIND_REPLAY, ring[rd_ptr], fill == 1);
            rd_ptr = step_ptr(rd_ptr);
            fill--;
          end
        end
        default: begin
          idle_ticks = '0;
        end
      endcase
    endfunction

    function void check_word(logic [1:0] kind, word_t word, logic last);
      result_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word: kind %0d word %h last %b", kind, word, last);
        return;
      end
      want = owed_words.pop_front();
      if (kind !== want.kind || word !== want.word || last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"result mismatch: expected kind %0d word %h last %b,",
                    " got kind %0d word %h last %b"},
                   want.kind, want.word, want.last, kind, word, last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata;   // [31:0] event_word
  logic [1:0]           s_tuser;   // [1:0] opcode
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;   // [31:0] event_word_out
  logic [1:0]           m_tuser;   // [1:0] kind
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TMO_W-1:0]     cfg_data;

  replay_scoreboard board;
  int unsigned      words_sent = 0;
  bit               src_gaps = 1'b1;
  bit               sink_stalls = 1'b1;
  bit               hold_request = 1'b0;
  bit               hold_active = 1'b0;

  gated_event_buffer_with_link_timeout i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // result side monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_word(m_tuser, m_tdata[EVENT_BITS-1:0], m_tlast);
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // offer one word and hold it until taken; valid stays high for a follow-on word
  task automatic push_word(op_t op, word_t w);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.accept_word(op, w);
    words_sent++;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop offering, wait for every owed word, then let the block go quiet
  task automatic settle();
    int unsigned guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (board.pending() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(logic [TMO_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_timeout(v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      phase_end;
    int unsigned      n;
    logic [TMO_W-1:0] tmo;

    board = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_TICK;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: link starts down, default timeout
    push_word(OP_TICK, 32'h0);
    push_word(OP_EVENT, 32'h0000_0000);
    push_word(OP_EVENT, 32'hFFFF_FFFF);
    push_word(OP_CMD, 32'hFFFF_FFFF);
    push_word(OP_IDENT, 32'h0);
    push_word(OP_EVENT, 32'hA5A5_A5A5);
    push_word(OP_IDENT, 32'hFFFF_FFFF);   // empty ring, marker alone

    // timeout of one tick: second tick drops the link
    write_timeout(16'd1);
    push_word(OP_TICK, $urandom());
    push_word(OP_TICK, $urandom());
    push_word(OP_CMD, $urandom());        // link stays down
    push_word(OP_EVENT, 32'h5A5A_5A5A);
    // one more than the ring holds, so the oldest entry is lost
    repeat (RING_DEPTH) push_word(OP_EVENT, $urandom());
    push_word(OP_IDENT, $urandom());

    // random phases, each with its own timeout
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: tmo = 16'd3;
        1: tmo = TMO_W'($urandom_range(1, 8));
        2: tmo = TMO_W'($urandom_range(1, 65535));
        3: tmo = TMO_W'($urandom_range(2, 6));
        default: tmo = TMO_W'($urandom_range(1, 4));
      endcase
      if (p == 4) begin
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      write_timeout(tmo);

      if (p == 3) begin
        // receiver holds off while the sender keeps pushing, so the input stalls
        hold_request = 1'b1;
        @(posedge clk);
        while (!hold_active) @(posedge clk);
        src_gaps = 1'b0;
        push_word(OP_IDENT, $urandom());
        repeat (16) push_word(OP_EVENT, $urandom());
        src_gaps = 1'b1;
      end

      phase_end = words_sent + RANDOM_WORDS / 5;
      while (words_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            push_word(op_t'($urandom_range(0, 3)), $urandom());
          end
          2, 3, 4: begin
            // burst of events, then an identify that replays any that were buffered
            repeat ($urandom_range(1, 20)) push_word(OP_EVENT, $urandom());
            push_word(OP_IDENT, $urandom());
          end
          5, 6: begin
            repeat ($urandom_range(1, 4)) push_word(OP_EVENT, $urandom());
          end
          7: begin
            // enough ticks to cross a short timeout
            n = (board.timeout < 10) ? board.timeout + 2 : 6;
            repeat ($urandom_range(1, n)) push_word(OP_TICK, $urandom());
          end
          8: begin
            push_word(OP_CMD, $urandom());
            repeat ($urandom_range(1, 3)) push_word(OP_TICK, $urandom());
          end
          default: begin
            push_word(OP_IDENT, $urandom());
          end
        endcase
      end
    end

    settle();
    if (board.pending() != 0)
      $display("%0d result words never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
src/geb_pkg.sv
src/geb_ctrl.sv
src/geb_datapath.sv
src/gated_event_buffer_with_link_timeout.sv
bench/testbench.sv
